/* rtl/arp_resp_pkg.sv */
// Shared types, constants and helper functions for the ARP request responder.
package arp_resp_pkg;

   localparam int TABLE_DEPTH_DEF = 8;
   localparam int ARP_FRAME_LEN   = 42;
   localparam int ETH_HDR_LEN     = 14;
   localparam int REPLY_W         = ARP_FRAME_LEN * 8;

   localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
   localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
   localparam logic [15:0] PROTO_IPV4     = 16'h0800;
   localparam logic [15:0] OP_REQUEST     = 16'h0001;
   localparam logic [15:0] OP_REPLY       = 16'h0002;
   localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
   localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;

   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic        command;
      logic [7:0]  frame_byte;
      logic        frame_last;
      logic [2:0]  entry_index;
      logic        entry_valid;
      logic [31:0] entry_ip;
      logic [47:0] entry_mac;
   } req_data_type;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic       reply_last;
   } rsp_data_type;

   // table write request
   typedef struct packed {
      logic        en;
      logic [2:0]  index;
      logic        valid;
      logic [31:0] ip;
      logic [47:0] mac;
   } tbl_wr_type;

   // table search result
   typedef struct packed {
      logic        done;
      logic        hit;
      logic [31:0] ip;
      logic [47:0] mac;
   } tbl_find_type;

   typedef struct packed {
      logic       check;
      logic [7:0] value;
   } hdr_expect_type;

   // Fixed header byte expected at a frame position, if any.
   function automatic hdr_expect_type expected_byte(input logic [5:0] pos);
      hdr_expect_type e;
      e.check = 1'b1;
      e.value = 8'h00;
      unique case (pos)
         6'd12:                 e.value = ETHERTYPE_ARP[15:8];
         6'd13:                 e.value = ETHERTYPE_ARP[7:0];
         6'(ETH_HDR_LEN + 0):   e.value = HW_TYPE_ETH[15:8];
         6'(ETH_HDR_LEN + 1):   e.value = HW_TYPE_ETH[7:0];
         6'(ETH_HDR_LEN + 2):   e.value = PROTO_IPV4[15:8];
         6'(ETH_HDR_LEN + 3):   e.value = PROTO_IPV4[7:0];
         6'(ETH_HDR_LEN + 4):   e.value = HW_ADDR_LEN;
         6'(ETH_HDR_LEN + 5):   e.value = PROTO_ADDR_LEN;
         6'(ETH_HDR_LEN + 6):   e.value = OP_REQUEST[15:8];
         6'(ETH_HDR_LEN + 7):   e.value = OP_REQUEST[7:0];
         default:               e.check = 1'b0;
      endcase
      return e;
   endfunction

   // Whole reply frame, first wire byte in the top bits.
   function automatic logic [REPLY_W-1:0] build_reply(input logic [47:0] dst_mac,
                                                      input logic [47:0] own_mac,
                                                      input logic [31:0] own_ip,
                                                      input logic [31:0] dst_ip);
      return {dst_mac, own_mac, ETHERTYPE_ARP, HW_TYPE_ETH, PROTO_IPV4,
              HW_ADDR_LEN, PROTO_ADDR_LEN, OP_REPLY, own_mac, own_ip,
              dst_mac, dst_ip};
   endfunction

endpackage

/* rtl/arp_resp_table.sv */
// Binding table with a one-entry-per-cycle lowest-index search.
module arp_resp_table
   import arp_resp_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  tbl_wr_type   wr,
   input  logic         start,
   input  logic [31:0]  wanted_ip,
   output tbl_find_type find
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic {T_IDLE, T_SCAN} tstate_type;

   logic [31:0] ip_mem  [TABLE_DEPTH];
   logic [47:0] mac_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   tstate_type       state_ff, state_in;
   logic             issue_ff, issue_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_live_ff, rd_live_in;
   logic [IDX_W-1:0] rd_tag_ff;
   logic [31:0]      rd_ip_ff;
   logic [47:0]      rd_mac_ff;

   logic [6:0]       wr_wide;
   logic             wr_ok;
   logic             match;
   logic             miss_end;

   assign wr_wide = {4'b0, wr.index};
   assign wr_ok   = wr.en && (wr_wide < 7'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_ok) begin
         valid_ff[wr_wide[IDX_W-1:0]] <= wr.valid;
      end
   end

   // storage plus registered read port
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         ip_mem[wr_wide[IDX_W-1:0]]  <= wr.ip;
         mac_mem[wr_wide[IDX_W-1:0]] <= wr.mac;
      end
      rd_ip_ff  <= ip_mem[rd_idx_ff];
      rd_mac_ff <= mac_mem[rd_idx_ff];
      rd_tag_ff <= rd_idx_ff;
   end

   // compare stage: the one comparator, shared by every entry
   assign match    = (state_ff == T_SCAN) && rd_live_ff && valid_ff[rd_tag_ff] &&
                     (rd_ip_ff == wanted_ip);
   assign miss_end = (state_ff == T_SCAN) && rd_live_ff && !match &&
                     (rd_tag_ff == LAST_IDX);

   assign find.done = match || miss_end;
   assign find.hit  = match;
   assign find.ip   = rd_ip_ff;
   assign find.mac  = rd_mac_ff;

   always_comb begin
      state_in   = state_ff;
      issue_in   = issue_ff;
      rd_idx_in  = rd_idx_ff;
      rd_live_in = 1'b0;
      unique case (state_ff)
         T_IDLE: begin
            if (start) begin
               state_in  = T_SCAN;
               issue_in  = 1'b1;
               rd_idx_in = '0;
            end
         end
         T_SCAN: begin
            if (find.done) begin
               state_in = T_IDLE;
               issue_in = 1'b0;
            end else if (issue_ff) begin
               rd_live_in = 1'b1;
               if (rd_idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= T_IDLE;
         issue_ff   <= 1'b0;
         rd_idx_ff  <= '0;
         rd_live_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         issue_ff   <= issue_in;
         rd_idx_ff  <= rd_idx_in;
         rd_live_ff <= rd_live_in;
      end
   end

endmodule

/* rtl/arp_request_responder.sv */
// ARP request responder: frame parser, search sequencer and reply shifter.
// Frame bytes and table writes are taken one per cycle while idle.
// After the final byte of a qualifying request, the table is searched one entry per
// cycle through the read port and comparator; on a hit, 42 reply bytes leave one per
// cycle from a shift register while rsp_stall is low; requests stall from that last
// byte until a miss ends the search or the final reply byte is taken.
// Reset (synchronous) clears frame state and empties the table; entry data is not cleared.
module arp_request_responder
   import arp_resp_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data
);

   typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_SEND} state_type;

   state_type          state_ff, state_in;
   logic [5:0]         count_ff, count_in;
   logic               hdr_ok_ff, hdr_ok_in;
   logic [47:0]        rmac_ff, rmac_in;
   logic [31:0]        rip_ff, rip_in;
   logic [31:0]        wip_ff, wip_in;
   logic [REPLY_W-1:0] reply_ff, reply_in;
   logic [5:0]         left_ff, left_in;

   logic               req_take;
   logic               rsp_take;
   logic               start;
   hdr_expect_type     want;
   tbl_wr_type         wr;
   tbl_find_type       find;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_SEND);
   assign rsp_data.reply_byte = reply_ff[REPLY_W-1 -: 8];
   assign rsp_data.reply_last = (left_ff == 6'd1);

   assign wr.en    = req_take && (req_data.command == CMD_WRITE);
   assign wr.index = req_data.entry_index;
   assign wr.valid = req_data.entry_valid;
   assign wr.ip    = req_data.entry_ip;
   assign wr.mac   = req_data.entry_mac;

   assign want = expected_byte(count_ff);

   arp_resp_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .start     (start),
      .wanted_ip (wip_ff),
      .find      (find)
   );

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      hdr_ok_in = hdr_ok_ff;
      rmac_in   = rmac_ff;
      rip_in    = rip_ff;
      wip_in    = wip_ff;
      reply_in  = reply_ff;
      left_in   = left_ff;
      start     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take && (req_data.command == CMD_FRAME)) begin
               if (count_ff < 6'(ARP_FRAME_LEN)) begin
                  if (want.check && (want.value != req_data.frame_byte)) begin
                     hdr_ok_in = 1'b0;
                  end
                  if (count_ff >= 6'd22 && count_ff < 6'd28) begin
                     rmac_in = {rmac_ff[39:0], req_data.frame_byte};
                  end else if (count_ff >= 6'd28 && count_ff < 6'd32) begin
                     rip_in = {rip_ff[23:0], req_data.frame_byte};
                  end else if (count_ff >= 6'd38) begin
                     wip_in = {wip_ff[23:0], req_data.frame_byte};
                  end
                  count_in = count_ff + 6'd1;
               end
               if (req_data.frame_last) begin
                  if (count_in == 6'(ARP_FRAME_LEN) && hdr_ok_in) begin
                     state_in = S_SEARCH;
                     start    = 1'b1;
                  end else begin
                     count_in  = '0;
                     hdr_ok_in = 1'b1;
                     rmac_in   = '0;
                     rip_in    = '0;
                     wip_in    = '0;
                  end
               end
            end
         end
         S_SEARCH: begin
            if (find.done) begin
               if (find.hit) begin
                  reply_in = build_reply(rmac_ff, find.mac, find.ip, rip_ff);
                  left_in  = 6'(ARP_FRAME_LEN);
                  state_in = S_SEND;
               end else begin
                  state_in = S_IDLE;
               end
               count_in  = '0;
               hdr_ok_in = 1'b1;
               rmac_in   = '0;
               rip_in    = '0;
               wip_in    = '0;
            end
         end
         S_SEND: begin
            if (rsp_take) begin
               reply_in = {reply_ff[REPLY_W-9:0], 8'h00};
               left_in  = left_ff - 6'd1;
               if (left_ff == 6'd1) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         hdr_ok_ff <= 1'b1;
         rmac_ff   <= '0;
         rip_ff    <= '0;
         wip_ff    <= '0;
         left_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         hdr_ok_ff <= hdr_ok_in;
         rmac_ff   <= rmac_in;
         rip_ff    <= rip_in;
         wip_ff    <= wip_in;
         left_ff   <= left_in;
      end
      reply_ff <= reply_in;
   end

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("reply active while requests are taken");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_data.reply_last |=> !rsp_valid && !req_stall)
      else $error("reply did not end after its final byte");

   a_find_in_search: assert property (@(posedge clock) disable iff (reset)
      find.done |-> state_ff == S_SEARCH)
      else $error("table search finished outside a search");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 6'(ARP_FRAME_LEN))
      else $error("byte count passed the frame length");
`endif

endmodule
